### hdl/imhq_pkg.sv
// Package for the indexed min-heap queue: sizes, item types, codes and states.
`default_nettype none
package imhq_pkg;
   localparam int CAPACITY    = 64;
   localparam int NUM_HANDLES = 64;
   localparam int KEY_WIDTH   = 32;
   localparam int POS_W       = $clog2(CAPACITY);
   localparam int CNT_W       = POS_W + 1;
   localparam int ID_W        = 6;

   typedef enum logic [2:0] {
      OP_INSERT  = 3'd0,
      OP_EXTRACT = 3'd1,
      OP_REMOVE  = 3'd2,
      OP_CHANGE  = 3'd3,
      OP_REPLACE = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_FULL    = 3'd2,
      ST_ABSENT  = 3'd3,
      ST_PRESENT = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_EXTR, S_LOAD, S_UP, S_UPCMP, S_DOWN, S_DNL,
      S_DNR, S_DNCMP, S_PLACE, S_ROOT, S_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]           operation;
      logic [ID_W-1:0]      element_id;
      logic [31:0]          key;
      logic [ID_W-1:0]      new_id;
   } req_type;

   typedef struct packed {
      logic                 removed_valid;
      logic [ID_W-1:0]      removed_id;
      logic                 min_valid;
      logic [ID_W-1:0]      min_id;
      logic [31:0]          min_key;
      logic [6:0]           entry_count;
      logic [2:0]           status;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]      handle;
      logic [KEY_WIDTH-1:0] key;
   } entry_type;
endpackage
`default_nettype wire

### hdl/indexed_min_heap_queue.sv
// Indexed binary min-heap queue: sequencer, heap store and handle position table.
//
// Usage: the requester presents one item on req_valid/req_data (operation,
// element_id, key, new_id) and it is accepted when req_ready is high. Each
// item produces exactly one result on rsp_valid/rsp_data: the removed
// handle, the root entry afterward, the entry count and a status code.
// One item at a time is worked on. An error item, an undefined operation,
// or an extract or remove that leaves no entry to move skips the sift;
// any other item sifts up and then down, one level at a time. All heap
// accesses go through one 64-entry heap memory with a registered read. The
// result sits in an output register; the next item may be accepted while
// that result still waits, and a stalled receiver only holds the block
// once a second result is ready. Reset (synchronous, active high) empties
// the heap and marks every handle absent at once; no clearing pass is
// needed.
`default_nettype none
module indexed_min_heap_queue import imhq_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
   entry_type heap_mem [CAPACITY];
   logic [POS_W-1:0] pos_mem [NUM_HANDLES];

   state_type state_ff, state_in;
   req_type req_ff;
   entry_type cur_ff, cur_in, child_ff, child_in, heap_rd_ff;
   logic [POS_W-1:0] p_ff, p_in, cidx_ff, cidx_in, pos_rd_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [NUM_HANDLES-1:0] hv_ff, hv_in;
   logic [2:0] status_ff, status_in;
   logic rem_v_ff, rem_v_in;
   logic [ID_W-1:0] rem_id_ff, rem_id_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic heap_we, pos_we;
   logic [POS_W-1:0] heap_wa, heap_ra, pos_wa, pos_wd;
   entry_type heap_wd;

   logic [CNT_W-1:0] last, lchild, rchild;
   logic [POS_W-1:0] parent;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (heap_we) heap_mem[heap_wa] <= heap_wd;
      heap_rd_ff <= heap_mem[heap_ra];
      if (pos_we) pos_mem[pos_wa] <= pos_wd;
      pos_rd_ff <= pos_mem[req_data.element_id];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         hv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hv_ff        <= hv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (state_ff == S_IDLE && req_valid) req_ff <= req_data;
      cur_ff    <= cur_in;
      child_ff  <= child_in;
      p_ff      <= p_in;
      cidx_ff   <= cidx_in;
      status_ff <= status_in;
      rem_v_ff  <= rem_v_in;
      rem_id_ff <= rem_id_in;
      rsp_ff    <= rsp_in;
   end

   assign last   = count_ff - CNT_W'(1);
   assign parent = POS_W'((p_ff - POS_W'(1)) >> 1);
   assign lchild = {p_ff, 1'b1};
   assign rchild = lchild + CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      child_in     = child_ff;
      p_in         = p_ff;
      cidx_in      = cidx_ff;
      count_in     = count_ff;
      hv_in        = hv_ff;
      status_in    = status_ff;
      rem_v_in     = rem_v_ff;
      rem_id_in    = rem_id_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      heap_we      = 1'b0;
      heap_wa      = p_ff;
      heap_wd      = cur_ff;
      heap_ra      = '0;
      pos_we       = 1'b0;
      pos_wa       = cur_ff.handle;
      pos_wd       = p_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            status_in = ST_OK;
            rem_v_in  = 1'b0;
            rem_id_in = '0;
            cur_in    = '{handle: req_ff.element_id, key: req_ff.key};
            state_in  = S_ROOT;
            case (req_ff.operation)
               OP_INSERT: begin
                  if (hv_ff[req_ff.element_id]) status_in = ST_PRESENT;
                  else if (count_ff >= CNT_W'(CAPACITY)) status_in = ST_FULL;
                  else begin
                     p_in = count_ff[POS_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                     hv_in[req_ff.element_id] = 1'b1;
                     state_in = S_UP;
                  end
               end
               OP_EXTRACT: begin
                  if (count_ff == '0) status_in = ST_EMPTY;
                  else begin
                     p_in = '0;
                     count_in = last;
                     heap_ra = '0;
                     state_in = S_EXTR;
                  end
               end
               OP_REMOVE: begin
                  if (!hv_ff[req_ff.element_id]) status_in = ST_ABSENT;
                  else begin
                     p_in = pos_rd_ff;
                     count_in = last;
                     hv_in[req_ff.element_id] = 1'b0;
                     rem_v_in = 1'b1;
                     rem_id_in = req_ff.element_id;
                     heap_ra = last[POS_W-1:0];
                     if (last[POS_W-1:0] != pos_rd_ff) state_in = S_LOAD;
                  end
               end
               OP_CHANGE: begin
                  if (!hv_ff[req_ff.element_id]) status_in = ST_ABSENT;
                  else begin
                     p_in = pos_rd_ff;
                     state_in = S_UP;
                  end
               end
               OP_REPLACE: begin
                  if (!hv_ff[req_ff.element_id]) status_in = ST_ABSENT;
                  else if (req_ff.new_id != req_ff.element_id && hv_ff[req_ff.new_id])
                     status_in = ST_PRESENT;
                  else begin
                     p_in = pos_rd_ff;
                     cur_in = '{handle: req_ff.new_id, key: req_ff.key};
                     if (req_ff.new_id != req_ff.element_id) begin
                        hv_in[req_ff.element_id] = 1'b0;
                        hv_in[req_ff.new_id] = 1'b1;
                        rem_v_in = 1'b1;
                        rem_id_in = req_ff.element_id;
                     end
                     state_in = S_UP;
                  end
               end
               default: state_in = S_ROOT;
            endcase
         end
         S_EXTR: begin
            // count already holds the index of the last entry
            hv_in[heap_rd_ff.handle] = 1'b0;
            rem_v_in  = 1'b1;
            rem_id_in = heap_rd_ff.handle;
            heap_ra   = count_ff[POS_W-1:0];
            state_in  = (count_ff == '0) ? S_ROOT : S_LOAD;
         end
         S_LOAD: begin
            cur_in   = heap_rd_ff;
            state_in = S_UP;
         end
         S_UP: begin
            heap_ra  = parent;
            state_in = (p_ff == '0) ? S_DOWN : S_UPCMP;
         end
         S_UPCMP: begin
            if (heap_rd_ff.key <= cur_ff.key) state_in = S_DOWN;
            else begin
               // move the parent down into the hole
               heap_we  = 1'b1;
               heap_wd  = heap_rd_ff;
               pos_we   = 1'b1;
               pos_wa   = heap_rd_ff.handle;
               p_in     = parent;
               state_in = S_UP;
            end
         end
         S_DOWN: begin
            heap_ra = lchild[POS_W-1:0];
            state_in = (lchild >= count_ff) ? S_PLACE : S_DNL;
         end
         S_DNL: begin
            child_in = heap_rd_ff;
            cidx_in  = lchild[POS_W-1:0];
            heap_ra  = rchild[POS_W-1:0];
            state_in = (rchild < count_ff) ? S_DNR : S_DNCMP;
         end
         S_DNR: begin
            if (heap_rd_ff.key < child_ff.key) begin
               child_in = heap_rd_ff;
               cidx_in  = rchild[POS_W-1:0];
            end
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            if (cur_ff.key <= child_ff.key) state_in = S_PLACE;
            else begin
               heap_we  = 1'b1;
               heap_wd  = child_ff;
               pos_we   = 1'b1;
               pos_wa   = child_ff.handle;
               p_in     = cidx_ff;
               state_in = S_DOWN;
            end
         end
         S_PLACE: begin
            heap_we  = 1'b1;
            pos_we   = 1'b1;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            heap_ra  = '0;
            state_in = S_RESP;
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.removed_valid = rem_v_ff;
               rsp_in.removed_id    = rem_id_ff;
               rsp_in.min_valid     = (count_ff != '0);
               rsp_in.min_id        = (count_ff != '0) ? heap_rd_ff.handle : '0;
               rsp_in.min_key       = (count_ff != '0) ? heap_rd_ff.key : '0;
               rsp_in.entry_count   = 7'(count_ff);
               rsp_in.status        = status_ff;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire
